>>> rtl/fcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants of the corner strength block
// Pixel, circle and score vector types, register map codes and pipeline depth.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int PIXEL_W       = 8;
  localparam int CIRCLE_POINTS = 16;
  localparam int POINT_W       = $clog2(CIRCLE_POINTS);
  localparam int LANE_PARTS    = 4;
  localparam int PIPE_DEPTH    = 6;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_ARC_TWELVE = 1'b1;

  localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd10;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CIRCLE_POINTS-1:0][PIXEL_W-1:0] circle_t;
  typedef logic [LANE_PARTS-1:0][PIXEL_W-1:0] part_vec_t;

  function automatic pixel_t min_px(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max_px(input pixel_t a, input pixel_t b);
    return (a > b) ? a : b;
  endfunction

endpackage : fcs_pkg
`default_nettype wire

>>> rtl/fcs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_lane: one polarity lane of the corner strength pipeline
// Forms the saturated differences of the 16 circle points, scores every
// contiguous arc by its minimum and reduces the 16 scores to four partial
// maxima, over four registered stages.
// ----------------------------------------------------------------------------
module fcs_lane
  import fcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      polarity_bright,
  input  wire circle_t   pix,
  input  wire pixel_t    ref_level,
  input  wire logic      arc_twelve,
  output part_vec_t      part_max
);

  circle_t   diff_r;
  circle_t   diff_nxt;
  circle_t   diff2_r;
  circle_t   w4_r;
  circle_t   w4_nxt;
  circle_t   score_r;
  circle_t   score_nxt;
  part_vec_t part_r;
  part_vec_t part_nxt;
  logic      arc1_r;
  logic      arc2_r;

  always_comb begin
    for (int k = 0; k < CIRCLE_POINTS; k++) begin
      diff_nxt[k] = '0;
      if (polarity_bright) begin
        if (pix[k] > ref_level) begin
          diff_nxt[k] = pix[k] - ref_level;
        end
      end else begin
        if (ref_level > pix[k]) begin
          diff_nxt[k] = ref_level - pix[k];
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < CIRCLE_POINTS; s++) begin
      w4_nxt[s] = min_px(min_px(diff_r[s], diff_r[POINT_W'(s + 1)]),
                         min_px(diff_r[POINT_W'(s + 2)], diff_r[POINT_W'(s + 3)]));
    end
  end

  always_comb begin
    pixel_t w8;
    pixel_t tail;
    for (int s = 0; s < CIRCLE_POINTS; s++) begin
      w8   = min_px(w4_r[s], w4_r[POINT_W'(s + 4)]);
      tail = arc2_r ? w4_r[POINT_W'(s + 8)] : diff2_r[POINT_W'(s + 8)];
      score_nxt[s] = min_px(w8, tail);
    end
  end

  always_comb begin
    for (int j = 0; j < LANE_PARTS; j++) begin
      part_nxt[j] = max_px(max_px(score_r[4*j], score_r[4*j+1]),
                           max_px(score_r[4*j+2], score_r[4*j+3]));
    end
  end

  always_ff @(posedge clk) begin
    diff_r  <= diff_nxt;
    arc1_r  <= arc_twelve;
    w4_r    <= w4_nxt;
    diff2_r <= diff_r;
    arc2_r  <= arc1_r;
    score_r <= score_nxt;
    part_r  <= part_nxt;
  end

  assign part_max = part_r;

endmodule : fcs_lane
`default_nettype wire

>>> rtl/fcs_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_merge: merging stage of the corner strength pipeline
// Takes the partial maxima of both polarity lanes and registers the largest.
// ----------------------------------------------------------------------------
module fcs_merge
  import fcs_pkg::*;
(
  input  wire logic      clk,
  input  wire part_vec_t dark_part,
  input  wire part_vec_t bright_part,
  output pixel_t         strength
);

  pixel_t strength_r;
  pixel_t strength_nxt;

  always_comb begin
    pixel_t dark_best;
    pixel_t bright_best;
    dark_best = max_px(max_px(dark_part[0], dark_part[1]),
                       max_px(dark_part[2], dark_part[3]));
    bright_best = max_px(max_px(bright_part[0], bright_part[1]),
                         max_px(bright_part[2], bright_part[3]));
    strength_nxt = max_px(dark_best, bright_best);
  end

  always_ff @(posedge clk) begin
    strength_r <= strength_nxt;
  end

  assign strength = strength_r;

endmodule : fcs_merge
`default_nettype wire

>>> rtl/fast_corner_strength_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fast_corner_strength_top: FAST-9 / FAST-12 corner strength, one pixel a clock
// Input words are a centre pixel, its 16 circle pixels and a row-end marker.
// A word is taken at each clock edge where start is high; busy stays low, so
// a new word may follow in every cycle.
// Each word yields one result word: out_valid is high for one cycle with the
// strength and the row-end copy once the word has passed the six-stage
// pipeline: a front register, four stages in each polarity lane and the
// merging stage. Throughput is one word per clock.
// The receiver cannot stall; results appear in input order.
// Threshold and arc length are written through the APB port at addresses
// 0 and 4 and take effect for words accepted afterwards.
// Synchronous reset clears the pipeline valid bits and sets the threshold
// to 10 and the arc length to nine points; words in flight are dropped.
// ----------------------------------------------------------------------------
module fast_corner_strength_top
  import fcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [7:0]            in_center_pixel,
  input  wire logic [63:0]           in_circle_low,
  input  wire logic [63:0]           in_circle_high,
  input  wire logic                  in_row_last,
  output logic                       out_valid,
  output logic [7:0]                 out_strength,
  output logic                       out_row_end,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  pixel_t                  threshold_r;
  pixel_t                  threshold_nxt;
  logic                    arc_twelve_r;
  logic                    arc_twelve_nxt;
  logic                    cfg_write;
  logic                    accept;
  circle_t                 pix_r;
  pixel_t                  dark_r;
  pixel_t                  dark_nxt;
  pixel_t                  bright_r;
  pixel_t                  bright_nxt;
  logic                    arc_r;
  logic [PIPE_DEPTH-1:0]   vld_r;
  logic [PIPE_DEPTH-1:0]   row_r;
  part_vec_t               dark_part;
  part_vec_t               bright_part;
  pixel_t                  strength;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    threshold_nxt  = threshold_r;
    arc_twelve_nxt = arc_twelve_r;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD:  threshold_nxt  = pwdata[PIXEL_W-1:0];
        REG_ARC_TWELVE: arc_twelve_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD:  prdata = {{(CFG_DATA_W-PIXEL_W){1'b0}}, threshold_r};
      REG_ARC_TWELVE: prdata = {{(CFG_DATA_W-1){1'b0}}, arc_twelve_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    logic [PIXEL_W:0] sum;
    sum = {1'b0, in_center_pixel} + {1'b0, threshold_r};
    dark_nxt   = (in_center_pixel > threshold_r) ? in_center_pixel - threshold_r : '0;
    bright_nxt = sum[PIXEL_W] ? {PIXEL_W{1'b1}} : sum[PIXEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RESET;
      arc_twelve_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      threshold_r  <= threshold_nxt;
      arc_twelve_r <= arc_twelve_nxt;
      vld_r        <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    pix_r    <= {in_circle_high, in_circle_low};
    dark_r   <= dark_nxt;
    bright_r <= bright_nxt;
    arc_r    <= arc_twelve_r;
    row_r    <= {row_r[PIPE_DEPTH-2:0], in_row_last};
  end

  fcs_lane u_lane_dark (
    .clk             (clk),
    .polarity_bright (1'b0),
    .pix             (pix_r),
    .ref_level       (dark_r),
    .arc_twelve      (arc_r),
    .part_max        (dark_part)
  );

  fcs_lane u_lane_bright (
    .clk             (clk),
    .polarity_bright (1'b1),
    .pix             (pix_r),
    .ref_level       (bright_r),
    .arc_twelve      (arc_r),
    .part_max        (bright_part)
  );

  fcs_merge u_merge (
    .clk         (clk),
    .dark_part   (dark_part),
    .bright_part (bright_part),
    .strength    (strength)
  );

  assign out_valid    = vld_r[PIPE_DEPTH-1];
  assign out_row_end  = row_r[PIPE_DEPTH-1];
  assign out_strength = strength;

endmodule : fast_corner_strength_top
`default_nettype wire

>>> rtl/fcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_checker: port-level checks of the corner strength block
// Checks result timing, marker transport and threshold register readback.
// ----------------------------------------------------------------------------
module fcs_checker
  import fcs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  in_row_last,
  input wire logic                  out_valid,
  input wire logic                  out_row_end,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [CFG_DATA_W-1:0] pwdata,
  input wire logic [CFG_DATA_W-1:0] prdata
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("Accepted word produced no result word.");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 6))
    else $error("Result word without an accepted input word.");

  a_row_end_carried: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end == $past(in_row_last, 6)))
    else $error("Row-end marker does not match its input word.");

  a_threshold_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD))
      |=> ((paddr[2] != REG_THRESHOLD) || (prdata[PIXEL_W-1:0] == $past(pwdata[PIXEL_W-1:0]))))
    else $error("Threshold readback differs from the written value.");

endmodule : fcs_checker

bind fast_corner_strength_top fcs_checker u_fcs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_row_last (in_row_last),
  .out_valid   (out_valid),
  .out_row_end (out_row_end),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
`default_nettype wire
